>>> rtl/core/bis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and codes of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

    // request kinds
    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SURF_W = 3'd0,
        CFG_SURF_H = 3'd1,
        CFG_RECT_L = 3'd2,
        CFG_RECT_T = 3'd3,
        CFG_RECT_W = 3'd4,
        CFG_RECT_H = 3'd5,
        CFG_DEST_W = 3'd6,
        CFG_DEST_H = 3'd7
    } t_cfg_idx;

    localparam int CFG_DATA_W = 13;

    // configuration register file
    typedef struct packed {
        logic [8:0]  surf_w;
        logic [8:0]  surf_h;
        logic [7:0]  rect_l;
        logic [7:0]  rect_t;
        logic [8:0]  rect_w;
        logic [8:0]  rect_h;
        logic [12:0] dest_w;
        logic [12:0] dest_h;
    } t_cfg;

    // one request as it travels down the pipe
    typedef struct packed {
        t_action     act;
        logic [7:0]  load_col;
        logic [7:0]  load_row;
        logic [31:0] pix;
        logic [11:0] dest_col;
        logic [11:0] dest_row;
    } t_item;

endpackage
`default_nettype wire

>>> rtl/core/bis_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bis_div #(
    parameter int NW = 30,
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] prem;
        logic [NW-1:0] pnum;
        logic [NW-1:0] pquo;
        logic [DW:0]   sh;
        logic          fits;

        if (k == 0) begin : g_first
            assign prem = '0;
            assign pnum = i_num;
            assign pquo = '0;
        end else begin : g_next
            assign prem = r_rem[k-1];
            assign pnum = r_num[k-1];
            assign pquo = r_quo[k-1];
        end

        // shift in next numerator bit, subtract when it fits
        assign sh   = {prem, pnum[NW-1-k]};
        assign fits = (sh >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= fits ? DW'(sh - {1'b0, i_den}) : sh[DW-1:0];
                r_num[k] <= pnum;
                r_quo[k] <= {pquo[NW-2:0], fits};
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule
`default_nettype wire

>>> rtl/core/bis_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_map
// Maps destination coordinates to fixed-point source positions.
// ----------------------------------------------------------------------------
module bis_map
    import bis_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int NW        = 22 + FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_item         i_item,
    input  t_cfg          i_cfg,
    output logic          o_valid,
    output t_item         o_item,
    output logic [NW-1:0] o_qx,
    output logic [NW-1:0] o_qy
);

    localparam int DW = 14;

    logic          r_v0;
    t_item         r_it0;
    logic [21:0]   r_prodx;
    logic [21:0]   r_prody;
    logic          r_vd [NW];
    t_item         r_itd [NW];
    logic [12:0]   dwx;
    logic [12:0]   dwy;
    logic [DW-1:0] denx;
    logic [DW-1:0] deny;

    // input register and (2d+1)*size products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it0   <= i_item;
            r_prodx <= 22'({i_item.dest_col, 1'b1}) * 22'(i_cfg.rect_w);
            r_prody <= 22'({i_item.dest_row, 1'b1}) * 22'(i_cfg.rect_h);
        end
    end

    // zero destination size acts as one
    assign dwx  = (i_cfg.dest_w == '0) ? 13'd1 : i_cfg.dest_w;
    assign dwy  = (i_cfg.dest_h == '0) ? 13'd1 : i_cfg.dest_h;
    assign denx = {dwx, 1'b0};
    assign deny = {dwy, 1'b0};

    bis_div #(.NW(NW), .DW(DW)) u_divx (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({r_prodx, FRAC_BITS'(0)}),
        .i_den (denx),
        .o_quo (o_qx)
    );

    bis_div #(.NW(NW), .DW(DW)) u_divy (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({r_prody, FRAC_BITS'(0)}),
        .i_den (deny),
        .o_quo (o_qy)
    );

    // valid and request ride alongside the divider stages
    for (genvar k = 0; k < NW; k++) begin : g_delay
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k] <= 1'b0;
            end else if (i_en) begin
                r_vd[k] <= (k == 0) ? r_v0 : r_vd[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_itd[k] <= (k == 0) ? r_it0 : r_itd[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_valid = r_vd[NW-1];
    assign o_item  = r_itd[NW-1];

endmodule
`default_nettype wire

>>> rtl/core/bis_fetch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_fetch
// Neighbor addressing and the four-bank source image store.
// ----------------------------------------------------------------------------
module bis_fetch
    import bis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 8,
    parameter int NW             = 22 + FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_item                i_item,
    input  logic [NW-1:0]        i_qx,
    input  logic [NW-1:0]        i_qy,
    input  t_cfg                 i_cfg,
    output logic                 o_valid,
    output t_action              o_act,
    output logic [31:0]          o_rd [4],
    output logic                 o_cpar,
    output logic                 o_rpar,
    output logic                 o_dropx,
    output logic                 o_dropy,
    output logic [FRAC_BITS-1:0] o_fx,
    output logic [FRAC_BITS-1:0] o_fy
);

    localparam int LW = NW - FRAC_BITS;
    localparam int CB = (MAX_SRC_WIDTH > 4) ? $clog2(MAX_SRC_WIDTH) : 2;
    localparam int RB = (MAX_SRC_HEIGHT > 4) ? $clog2(MAX_SRC_HEIGHT) : 2;
    localparam int AW = (CB - 1) + (RB - 1);
    localparam int BD = 1 << AW;

    logic                 copy;
    logic [NW-1:0]        px;
    logic [NW-1:0]        py;
    logic [LW-1:0]        lx;
    logic [LW-1:0]        ly;
    logic [LW:0]          rx;
    logic [LW:0]          ry;
    logic [CB+7:0]        lcol_w;
    logic [RB+7:0]        lrow_w;

    logic                 r_va;
    t_action              r_act;
    logic                 r_wr_ok;
    logic [CB-1:0]        r_lcol;
    logic [RB-1:0]        r_lrow;
    logic [31:0]          r_pix;
    logic [CB-1:0]        r_col;
    logic [RB-1:0]        r_row;
    logic                 r_dropx;
    logic                 r_dropy;
    logic [FRAC_BITS-1:0] r_fx;
    logic [FRAC_BITS-1:0] r_fy;

    logic [CB-1:0]        cr;
    logic [RB-1:0]        rb;
    logic [1:0]           wbank;
    logic [AW-1:0]        waddr;
    logic                 we;

    logic                 r_vm;
    t_action              r_actm;
    logic                 r_cpar;
    logic                 r_rpar;
    logic                 r_dropxm;
    logic                 r_dropym;
    logic [FRAC_BITS-1:0] r_fxm;
    logic [FRAC_BITS-1:0] r_fym;

    // source positions; equal sizes give a straight copy
    assign copy = (i_cfg.rect_w == i_cfg.dest_w) && (i_cfg.rect_h == i_cfg.dest_h);
    assign px   = i_qx + (NW'(i_cfg.rect_l) << FRAC_BITS);
    assign py   = i_qy + (NW'(i_cfg.rect_t) << FRAC_BITS);
    assign lx   = copy ? LW'(i_cfg.rect_l) + LW'(i_item.dest_col) : px[NW-1:FRAC_BITS];
    assign ly   = copy ? LW'(i_cfg.rect_t) + LW'(i_item.dest_row) : py[NW-1:FRAC_BITS];
    assign rx   = (LW+1)'(lx) + (LW+1)'(1);
    assign ry   = (LW+1)'(ly) + (LW+1)'(1);

    assign lcol_w = (CB+8)'(i_item.load_col);
    assign lrow_w = (RB+8)'(i_item.load_row);

    // address stage: saturate, edge test, weights
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act   <= i_item.act;
            r_wr_ok <= (lcol_w < (CB+8)'(MAX_SRC_WIDTH)) &&
                       (lrow_w < (RB+8)'(MAX_SRC_HEIGHT));
            r_lcol  <= lcol_w[CB-1:0];
            r_lrow  <= lrow_w[RB-1:0];
            r_pix   <= i_item.pix;
            r_col   <= (lx > LW'(MAX_SRC_WIDTH - 1)) ? CB'(MAX_SRC_WIDTH - 1) : lx[CB-1:0];
            r_row   <= (ly > LW'(MAX_SRC_HEIGHT - 1)) ? RB'(MAX_SRC_HEIGHT - 1) : ly[RB-1:0];
            r_dropx <= copy || (rx >= (LW+1)'(i_cfg.surf_w)) ||
                       (rx >= (LW+1)'(MAX_SRC_WIDTH));
            r_dropy <= copy || (ry >= (LW+1)'(i_cfg.surf_h)) ||
                       (ry >= (LW+1)'(MAX_SRC_HEIGHT));
            r_fx    <= copy ? '0 : px[FRAC_BITS-1:0];
            r_fy    <= copy ? '0 : py[FRAC_BITS-1:0];
        end
    end

    // bank select by row and column parity
    assign cr    = r_col + CB'(1);
    assign rb    = r_row + RB'(1);
    assign wbank = {r_lrow[0], r_lcol[0]};
    assign waddr = {r_lrow[RB-1:1], r_lcol[CB-1:1]};
    assign we    = i_en && r_va && (r_act == ACT_LOAD) && r_wr_ok;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic RP = 1'((b >> 1) & 1);
        localparam logic CP = 1'(b & 1);

        logic [31:0]   mem [BD];
        logic [RB-1:0] rsel;
        logic [CB-1:0] csel;
        logic [AW-1:0] raddr;

        assign rsel  = (r_row[0] == RP) ? r_row : rb;
        assign csel  = (r_col[0] == CP) ? r_col : cr;
        assign raddr = {rsel[RB-1:1], csel[CB-1:1]};

        always_ff @(posedge i_clk) begin
            if (we && (wbank == 2'(b))) begin
                mem[waddr] <= r_pix;
            end
            if (i_en) begin
                o_rd[b] <= mem[raddr];
            end
        end
    end

    // memory stage side data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (i_en) begin
            r_vm <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_actm   <= r_act;
            r_cpar   <= r_col[0];
            r_rpar   <= r_row[0];
            r_dropxm <= r_dropx;
            r_dropym <= r_dropy;
            r_fxm    <= r_fx;
            r_fym    <= r_fy;
        end
    end

    assign o_valid = r_vm;
    assign o_act   = r_actm;
    assign o_cpar  = r_cpar;
    assign o_rpar  = r_rpar;
    assign o_dropx = r_dropxm;
    assign o_dropy = r_dropym;
    assign o_fx    = r_fxm;
    assign o_fy    = r_fym;

endmodule
`default_nettype wire

>>> rtl/core/bis_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_blend
// Horizontal then vertical blend with round half up, output register.
// ----------------------------------------------------------------------------
module bis_blend
    import bis_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_action              i_act,
    input  logic [31:0]          i_rd [4],
    input  logic                 i_cpar,
    input  logic                 i_rpar,
    input  logic                 i_dropx,
    input  logic                 i_dropy,
    input  logic [FRAC_BITS-1:0] i_fx,
    input  logic [FRAC_BITS-1:0] i_fy,
    output logic                 o_valid,
    output logic [31:0]          o_pix
);

    localparam int SW = FRAC_BITS + 9;

    function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                          input logic [FRAC_BITS-1:0] f);
        logic [FRAC_BITS:0] wa;
        logic [SW-1:0]      s;
        wa = ((FRAC_BITS+1)'(1) << FRAC_BITS) - (FRAC_BITS+1)'(f);
        s  = SW'(a) * SW'(wa) + SW'(b) * SW'(f) + (SW'(1) << (FRAC_BITS - 1));
        return s[FRAC_BITS+7:FRAC_BITS];
    endfunction

    function automatic logic [31:0] blend32(input logic [31:0] a, input logic [31:0] b,
                                            input logic [FRAC_BITS-1:0] f);
        logic [31:0] r;
        for (int c = 0; c < 4; c++) begin
            r[c*8 +: 8] = blend8(a[c*8 +: 8], b[c*8 +: 8], f);
        end
        return r;
    endfunction

    logic [31:0]          tl;
    logic [31:0]          tr;
    logic [31:0]          bl;
    logic [31:0]          br;
    logic [31:0]          tr_e;
    logic [31:0]          bl_e;
    logic [31:0]          br_e;

    logic                 r_vh;
    t_action              r_acth;
    logic [31:0]          r_top;
    logic [31:0]          r_bot;
    logic [FRAC_BITS-1:0] r_fy;
    logic                 r_vo;
    logic [31:0]          r_pix;

    // place banks as top-left, top-right, bottom-left, bottom-right
    assign tl = i_rd[{i_rpar, i_cpar}];
    assign tr = i_rd[{i_rpar, ~i_cpar}];
    assign bl = i_rd[{~i_rpar, i_cpar}];
    assign br = i_rd[{~i_rpar, ~i_cpar}];

    // dropped neighbors repeat the near pixel
    assign tr_e = i_dropx ? tl : tr;
    assign bl_e = i_dropy ? tl : bl;
    assign br_e = i_dropy ? tr_e : (i_dropx ? bl : br);

    // horizontal stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh <= 1'b0;
        end else if (i_en) begin
            r_vh <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acth <= i_act;
            r_top  <= blend32(tl, tr_e, i_fx);
            r_bot  <= blend32(bl_e, br_e, i_fx);
            r_fy   <= i_dropy ? '0 : i_fy;
        end
    end

    // vertical stage into the output register; loads leave a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_vh && (r_acth == ACT_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= blend32(r_top, r_bot, r_fy);
        end
    end

    assign o_valid = r_vo;
    assign o_pix   = r_pix;

endmodule
`default_nettype wire

>>> rtl/core/bilinear_image_scaler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_image_scaler_unit
// Bilinear RGBA8 scaler with a source image store loaded by requests.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     i_valid / o_stall     i_action, i_load_*, i_in_*, i_dest_*
//  output    o_valid / i_stall     o_out_red/green/blue/alpha
//  config    i_cfg_we              i_cfg_idx, i_cfg_data
//
//  One request per cycle while no stall holds the pipe; the source position comes
//  from the one-bit-per-stage divider.
//  The store has four parity banks so the 2x2 neighborhood is read from all banks at once.
//  Reset clears the valid bits and loads register defaults; the store is not cleared.
//  A stall on the output freezes every stage while a result waits there; o_stall follows it directly.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_unit
    import bis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_action,
    input  logic [7:0]            i_load_col,
    input  logic [7:0]            i_load_row,
    input  logic [7:0]            i_in_red,
    input  logic [7:0]            i_in_green,
    input  logic [7:0]            i_in_blue,
    input  logic [7:0]            i_in_alpha,
    input  logic [11:0]           i_dest_col,
    input  logic [11:0]           i_dest_row,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_alpha
);

    localparam int NW = 22 + FRAC_BITS;

    t_cfg                 r_cfg;
    logic                 adv;
    t_item                item;
    logic                 mv;
    t_item                mitem;
    logic [NW-1:0]        qx;
    logic [NW-1:0]        qy;
    logic                 fv;
    t_action              fact;
    logic [31:0]          frd [4];
    logic                 fcpar;
    logic                 frpar;
    logic                 fdropx;
    logic                 fdropy;
    logic [FRAC_BITS-1:0] ffx;
    logic [FRAC_BITS-1:0] ffy;
    logic [31:0]          pix;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.surf_w <= 9'd256;
            r_cfg.surf_h <= 9'd256;
            r_cfg.rect_l <= 8'd0;
            r_cfg.rect_t <= 8'd0;
            r_cfg.rect_w <= 9'd256;
            r_cfg.rect_h <= 9'd256;
            r_cfg.dest_w <= 13'd256;
            r_cfg.dest_h <= 13'd256;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SURF_W: r_cfg.surf_w <= i_cfg_data[8:0];
                CFG_SURF_H: r_cfg.surf_h <= i_cfg_data[8:0];
                CFG_RECT_L: r_cfg.rect_l <= i_cfg_data[7:0];
                CFG_RECT_T: r_cfg.rect_t <= i_cfg_data[7:0];
                CFG_RECT_W: r_cfg.rect_w <= i_cfg_data[8:0];
                CFG_RECT_H: r_cfg.rect_h <= i_cfg_data[8:0];
                CFG_DEST_W: r_cfg.dest_w <= i_cfg_data;
                CFG_DEST_H: r_cfg.dest_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe moves unless a result waits at the output
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    assign item.act      = t_action'(i_action);
    assign item.load_col = i_load_col;
    assign item.load_row = i_load_row;
    assign item.pix      = {i_in_alpha, i_in_blue, i_in_green, i_in_red};
    assign item.dest_col = i_dest_col;
    assign item.dest_row = i_dest_row;

    bis_map #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_valid (mv),
        .o_item  (mitem),
        .o_qx    (qx),
        .o_qy    (qy)
    );

    bis_fetch #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .FRAC_BITS      (FRAC_BITS),
        .NW             (NW)
    ) u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (mv),
        .i_item  (mitem),
        .i_qx    (qx),
        .i_qy    (qy),
        .i_cfg   (r_cfg),
        .o_valid (fv),
        .o_act   (fact),
        .o_rd    (frd),
        .o_cpar  (fcpar),
        .o_rpar  (frpar),
        .o_dropx (fdropx),
        .o_dropy (fdropy),
        .o_fx    (ffx),
        .o_fy    (ffy)
    );

    bis_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (fv),
        .i_act   (fact),
        .i_rd    (frd),
        .i_cpar  (fcpar),
        .i_rpar  (frpar),
        .i_dropx (fdropx),
        .i_dropy (fdropy),
        .i_fx    (ffx),
        .i_fy    (ffy),
        .o_valid (o_valid),
        .o_pix   (pix)
    );

    assign o_out_red   = pix[7:0];
    assign o_out_green = pix[15:8];
    assign o_out_blue  = pix[23:16];
    assign o_out_alpha = pix[31:24];

endmodule
`default_nettype wire
